### design/tfd_pkg.sv
`timescale 1ns / 1ps
// shared widths, reset values, verdict codes and types of the frame decimator
package tfd_pkg;

    localparam int STAMP_W = 63;
    localparam int TIME_W  = 64;
    localparam int IVL_W   = 30;
    localparam int CNT_W   = 32;
    localparam int STEP_W  = 6;

    localparam logic [IVL_W-1:0] INTERVAL_RESET = 30'd125000000;
    localparam logic [CNT_W-1:0] COUNT_MAX      = {CNT_W{1'b1}};

    localparam logic [1:0] VERDICT_UNTIMED = 2'd0;
    localparam logic [1:0] VERDICT_RESYNC  = 2'd1;
    localparam logic [1:0] VERDICT_DROP    = 2'd2;
    localparam logic [1:0] VERDICT_SCHED   = 2'd3;

    // request to the remainder unit
    typedef struct packed {
        logic               start;
        logic [STAMP_W-1:0] dividend;
        logic [IVL_W-1:0]   divisor;
    } rem_req_t;

    // status back from the remainder unit
    typedef struct packed {
        logic             busy;
        logic             done;
        logic [IVL_W-1:0] rem;
    } rem_stat_t;

endpackage

### design/tfd_ifs.sv
`timescale 1ns / 1ps
// valid/ready channel interfaces of the frame decimator

interface tfd_frame_if;
    logic                         valid;
    logic                         ready;
    logic                         stamp_valid;
    logic [tfd_pkg::STAMP_W-1:0]  stamp;
    logic                         count_enable;

    modport source (output valid, output stamp_valid, output stamp, output count_enable,
                    input ready);
    modport sink   (input valid, input stamp_valid, input stamp, input count_enable,
                    output ready);
endinterface

interface tfd_result_if;
    logic                       valid;
    logic                       ready;
    logic                       admit;
    logic [1:0]                 verdict;
    logic [tfd_pkg::CNT_W-1:0]  admitted_total;
    logic [tfd_pkg::CNT_W-1:0]  dropped_total;

    modport source (output valid, output admit, output verdict, output admitted_total,
                    output dropped_total, input ready);
    modport sink   (input valid, input admit, input verdict, input admitted_total,
                    input dropped_total, output ready);
endinterface

interface tfd_cfg_if;
    logic                       valid;
    logic                       ready;
    logic [tfd_pkg::IVL_W-1:0]  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### design/tfd_rem_unit.sv
`timescale 1ns / 1ps
// bit-serial restoring remainder unit, one dividend bit per cycle
module tfd_rem_unit
(
    input  logic               clk,
    input  logic               rst_n,
    input  tfd_pkg::rem_req_t  req,
    output tfd_pkg::rem_stat_t stat
);

    localparam logic [tfd_pkg::STEP_W-1:0] LAST_STEP = tfd_pkg::STEP_W'(tfd_pkg::STAMP_W - 1);

    logic                          busy_reg;
    logic                          done_reg;
    logic [tfd_pkg::STEP_W-1:0]    step_reg;
    logic [tfd_pkg::STAMP_W-1:0]   shift_reg;
    logic [tfd_pkg::IVL_W-1:0]     rem_reg;
    logic [tfd_pkg::IVL_W-1:0]     divisor_reg;

    logic [tfd_pkg::IVL_W:0]       trial;
    logic [tfd_pkg::IVL_W:0]       diff;
    logic [tfd_pkg::IVL_W-1:0]     rem_step;

    // shift in the next bit, subtract when it fits
    always_comb
    begin
        trial = {rem_reg, shift_reg[tfd_pkg::STAMP_W-1]};
        diff  = trial - {1'b0, divisor_reg};
        if (trial >= {1'b0, divisor_reg})
        begin
            rem_step = diff[tfd_pkg::IVL_W-1:0];
        end
        else
        begin
            rem_step = trial[tfd_pkg::IVL_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                step_reg <= LAST_STEP;
            end
            else if (busy_reg)
            begin
                if (step_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    step_reg <= step_reg - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            shift_reg   <= req.dividend;
            divisor_reg <= req.divisor;
            rem_reg     <= '0;
        end
        else if (busy_reg)
        begin
            shift_reg <= {shift_reg[tfd_pkg::STAMP_W-2:0], 1'b0};
            rem_reg   <= rem_step;
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign stat.rem  = rem_reg;

endmodule

### design/timestamp_frame_decimator_core.sv
`timescale 1ns / 1ps
// top level of the timestamp frame decimator
//
// Each request on frame is one video frame with an optional 63-bit timestamp in ns;
// each request on result gives admit, verdict and the saturating admitted and dropped
// totals after that frame. Frames are taken one at a time: an untimed, resync or early
// frame passes S_CLASS and S_FIN, while a scheduled frame first waits in S_DIV for the
// 63-step bit-serial remainder unit that finds (stamp - due) mod interval one dividend
// bit per cycle. The new due time is then stamp + interval - remainder.
// A result waiting in the output register does not keep the next frame from being
// accepted. cfg writes frame_interval (0 acts as 1 ns) and is always ready; a new
// interval is used from the next due-time update on.
module timestamp_frame_decimator_core
(
    input  logic          clk,
    input  logic          rst_n,
    tfd_frame_if.sink     frame,
    tfd_result_if.source  result,
    tfd_cfg_if.sink       cfg
);

    // sequencer states
    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_CLASS = 2'd1;
    localparam logic [1:0] S_DIV   = 2'd2;
    localparam logic [1:0] S_FIN   = 2'd3;

    logic [1:0]                    state_reg, state_next;
    logic [tfd_pkg::IVL_W-1:0]     interval_reg;

    // latched frame
    logic                          sv_reg;
    logic [tfd_pkg::STAMP_W-1:0]   stamp_reg;
    logic                          cnt_en_reg;

    // decimator state
    logic [tfd_pkg::TIME_W-1:0]    due_reg, due_next;
    logic                          due_known_reg, due_known_next;
    logic [tfd_pkg::TIME_W-1:0]    prev_reg, prev_next;
    logic                          prev_known_reg, prev_known_next;
    logic [tfd_pkg::CNT_W-1:0]     admit_cnt_reg, admit_cnt_next;
    logic [tfd_pkg::CNT_W-1:0]     drop_cnt_reg, drop_cnt_next;
    logic [1:0]                    verdict_reg, verdict_next;

    // output register
    logic                          out_valid_reg, out_valid_next;
    logic                          out_admit_reg;
    logic [1:0]                    out_verdict_reg;
    logic [tfd_pkg::CNT_W-1:0]     out_admitted_reg;
    logic [tfd_pkg::CNT_W-1:0]     out_dropped_reg;
    logic                          out_load;

    logic [tfd_pkg::IVL_W-1:0]     ivl;
    logic [tfd_pkg::TIME_W-1:0]    stamp_ext;
    logic [tfd_pkg::TIME_W-1:0]    diff_full;
    logic [tfd_pkg::IVL_W-1:0]     ivl_minus_rem;
    logic                          is_admit;

    tfd_pkg::rem_req_t             rem_req;
    tfd_pkg::rem_stat_t            rem_stat;

    tfd_rem_unit u_rem
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (rem_req),
        .stat  (rem_stat)
    );

    // zero interval lies outside the range and acts as 1 ns
    assign ivl = (interval_reg == '0) ? tfd_pkg::IVL_W'(1) : interval_reg;

    assign stamp_ext     = {1'b0, stamp_reg};
    assign diff_full     = stamp_ext - due_reg;
    assign ivl_minus_rem = ivl - rem_stat.rem;
    assign is_admit      = (verdict_reg != tfd_pkg::VERDICT_DROP);

    assign frame.ready = (state_reg == S_IDLE);
    assign cfg.ready   = 1'b1;

    // output slot is free when empty or being taken this cycle
    assign out_load = (state_reg == S_FIN) && (!out_valid_reg || result.ready);

    always_comb
    begin
        state_next      = state_reg;
        due_next        = due_reg;
        due_known_next  = due_known_reg;
        prev_next       = prev_reg;
        prev_known_next = prev_known_reg;
        admit_cnt_next  = admit_cnt_reg;
        drop_cnt_next   = drop_cnt_reg;
        verdict_next    = verdict_reg;
        out_valid_next  = out_valid_reg;

        rem_req.start    = 1'b0;
        rem_req.dividend = diff_full[tfd_pkg::STAMP_W-1:0];
        rem_req.divisor  = ivl;

        if (out_valid_reg && result.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (frame.valid)
                begin
                    state_next = S_CLASS;
                end
            end
            S_CLASS:
            begin
                state_next = S_FIN;
                if (!sv_reg)
                begin
                    verdict_next = tfd_pkg::VERDICT_UNTIMED;
                end
                else if (!due_known_reg || (prev_known_reg && (stamp_ext < prev_reg)))
                begin
                    // first timed frame or stamp went backwards
                    prev_next       = stamp_ext;
                    prev_known_next = 1'b1;
                    due_next        = stamp_ext + tfd_pkg::TIME_W'(ivl);
                    due_known_next  = 1'b1;
                    verdict_next    = tfd_pkg::VERDICT_RESYNC;
                end
                else
                begin
                    prev_next       = stamp_ext;
                    prev_known_next = 1'b1;
                    if (stamp_ext < due_reg)
                    begin
                        verdict_next = tfd_pkg::VERDICT_DROP;
                    end
                    else
                    begin
                        // due moves by whole intervals past the stamp
                        verdict_next  = tfd_pkg::VERDICT_SCHED;
                        rem_req.start = 1'b1;
                        state_next    = S_DIV;
                    end
                end
            end
            S_DIV:
            begin
                if (rem_stat.done)
                begin
                    due_next   = stamp_ext + tfd_pkg::TIME_W'(ivl_minus_rem);
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                if (out_load)
                begin
                    if (cnt_en_reg)
                    begin
                        if (is_admit)
                        begin
                            if (admit_cnt_reg != tfd_pkg::COUNT_MAX)
                            begin
                                admit_cnt_next = admit_cnt_reg + 1'b1;
                            end
                        end
                        else if (drop_cnt_reg != tfd_pkg::COUNT_MAX)
                        begin
                            drop_cnt_next = drop_cnt_reg + 1'b1;
                        end
                    end
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            interval_reg   <= tfd_pkg::INTERVAL_RESET;
            due_reg        <= '0;
            due_known_reg  <= 1'b0;
            prev_reg       <= '0;
            prev_known_reg <= 1'b0;
            admit_cnt_reg  <= '0;
            drop_cnt_reg   <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            due_reg        <= due_next;
            due_known_reg  <= due_known_next;
            prev_reg       <= prev_next;
            prev_known_reg <= prev_known_next;
            admit_cnt_reg  <= admit_cnt_next;
            drop_cnt_reg   <= drop_cnt_next;
            out_valid_reg  <= out_valid_next;
            if (cfg.valid)
            begin
                interval_reg <= cfg.data;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        verdict_reg <= verdict_next;
        if (frame.valid && frame.ready)
        begin
            sv_reg     <= frame.stamp_valid;
            stamp_reg  <= frame.stamp;
            cnt_en_reg <= frame.count_enable;
        end
        if (out_load)
        begin
            out_admit_reg    <= is_admit;
            out_verdict_reg  <= verdict_reg;
            out_admitted_reg <= admit_cnt_next;
            out_dropped_reg  <= drop_cnt_next;
        end
    end

    assign result.valid          = out_valid_reg;
    assign result.admit          = out_admit_reg;
    assign result.verdict        = out_verdict_reg;
    assign result.admitted_total = out_admitted_reg;
    assign result.dropped_total  = out_dropped_reg;

endmodule

### sim/timestamp_frame_decimator_core_tb.sv
`timescale 1ns / 1ps
// self-checking testbench of the timestamp frame decimator: directed table, then random phases
module timestamp_frame_decimator_core_tb;

    localparam int CLK_PERIOD      = 20;
    localparam int RESET_CYCLES    = 4;
    localparam int PHASES          = 8;
    localparam int ITEMS_PER_PHASE = 125;
    localparam int SETTLE_CYCLES   = 8;     // idle margin before an interval write
    localparam int HOLD_CYCLES     = 400;   // long receiver hold-off
    localparam int END_CYCLES      = 100;   // beyond the scheduled-frame latency
    localparam int QUIET_LIMIT     = 3000;  // cycles with no request accepted anywhere
    localparam int SHOWN_MISMATCHES = 10;

    localparam logic [tfd_pkg::STAMP_W-1:0] STAMP_MAX = '1;
    localparam logic [tfd_pkg::IVL_W-1:0]   IVL_MAX   = '1;

    typedef struct packed {
        logic                      admit;
        logic [1:0]                verdict;
        logic [tfd_pkg::CNT_W-1:0] admitted_total;
        logic [tfd_pkg::CNT_W-1:0] dropped_total;
    } frame_outcome_t;

    typedef enum bit {ROW_FRAME, ROW_CFG} row_kind_t;

    typedef struct {
        row_kind_t                   kind;
        bit                          stamp_valid;
        logic [tfd_pkg::STAMP_W-1:0] stamp;
        bit                          count_enable;
        logic [tfd_pkg::IVL_W-1:0]   interval;
        bit                          typed;      // outcome written out by hand in the table
        frame_outcome_t              want;
    } stim_row_t;

    logic clk;
    logic rst_n;

    tfd_frame_if  frame_ch ();
    tfd_result_if result_ch ();
    tfd_cfg_if    cfg_ch ();

    timestamp_frame_decimator_core u_dut
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .frame  (frame_ch),
        .result (result_ch),
        .cfg    (cfg_ch)
    );

    // decimator state as the testbench sees it
    logic [tfd_pkg::IVL_W-1:0]  cur_interval;
    logic [tfd_pkg::TIME_W-1:0] due_ns;
    bit                         due_valid;
    logic [tfd_pkg::TIME_W-1:0] last_stamp;
    bit                         last_valid;
    logic [tfd_pkg::CNT_W-1:0]  admitted;
    logic [tfd_pkg::CNT_W-1:0]  dropped;

    // outcomes still owed by the block, oldest first
    frame_outcome_t pending_outcomes[$];
    stim_row_t      stim_table[$];

    // run bookkeeping
    int  frames_sent;
    int  directed_frames;
    int  interval_writes;
    int  results_checked;
    int  mismatches;
    int  verdict_seen[4];
    int  burst_left;
    bit  bursty;
    bit  rx_stall_on;
    bit  hold_req;
    logic [15:0] rx_pattern;
    int  hold_left;
    int  quiet_cycles;

    // free-running clock
    initial clk = 1'b0;
    always #(CLK_PERIOD / 2) clk = ~clk;

    // expected outcome of one frame; advances the due time and the counters
    function automatic frame_outcome_t decimate_frame(
        input bit                          stamp_valid,
        input logic [tfd_pkg::STAMP_W-1:0] stamp,
        input bit                          count_enable);
        frame_outcome_t             o;
        logic [tfd_pkg::TIME_W-1:0] step;
        logic [tfd_pkg::TIME_W-1:0] stamp64;
        logic [tfd_pkg::TIME_W-1:0] periods;
        // zero interval behaves as one ns
        step    = (cur_interval == '0) ? tfd_pkg::TIME_W'(1) : tfd_pkg::TIME_W'(cur_interval);
        stamp64 = tfd_pkg::TIME_W'(stamp);
        if (!stamp_valid)
        begin
            // untimed frames pass and leave the schedule alone
            o.admit   = 1'b1;
            o.verdict = tfd_pkg::VERDICT_UNTIMED;
        end
        else if (!due_valid || (last_valid && stamp64 < last_stamp))
        begin
            // first timed frame or a stamp that went backwards
            last_stamp = stamp64;
            last_valid = 1'b1;
            due_ns     = stamp64 + step;
            due_valid  = 1'b1;
            o.admit    = 1'b1;
            o.verdict  = tfd_pkg::VERDICT_RESYNC;
        end
        else
        begin
            last_stamp = stamp64;
            last_valid = 1'b1;
            if (stamp64 < due_ns)
            begin
                o.admit   = 1'b0;
                o.verdict = tfd_pkg::VERDICT_DROP;
            end
            else
            begin
                // jump the due time past the frame in whole intervals
                periods   = (stamp64 - due_ns) / step + tfd_pkg::TIME_W'(1);
                due_ns    = due_ns + periods * step;
                o.admit   = 1'b1;
                o.verdict = tfd_pkg::VERDICT_SCHED;
            end
        end
        if (count_enable)
        begin
            if (o.admit)
            begin
                if (admitted != tfd_pkg::COUNT_MAX)
                    admitted = admitted + 1'b1;
            end
            else if (dropped != tfd_pkg::COUNT_MAX)
                dropped = dropped + 1'b1;
        end
        o.admitted_total = admitted;
        o.dropped_total  = dropped;
        verdict_seen[o.verdict]++;
        return o;
    endfunction

    task automatic add_frame(input bit stamp_valid,
                             input logic [tfd_pkg::STAMP_W-1:0] stamp,
                             input bit count_enable, input bit typed,
                             input logic want_admit, input logic [1:0] want_verdict,
                             input logic [tfd_pkg::CNT_W-1:0] want_admitted,
                             input logic [tfd_pkg::CNT_W-1:0] want_dropped);
        stim_row_t r;
        r.kind         = ROW_FRAME;
        r.stamp_valid  = stamp_valid;
        r.stamp        = stamp;
        r.count_enable = count_enable;
        r.interval     = '0;
        r.typed        = typed;
        r.want         = '{want_admit, want_verdict, want_admitted, want_dropped};
        stim_table.insert(stim_table.size(), r);
    endtask

    task automatic add_cfg(input logic [tfd_pkg::IVL_W-1:0] interval);
        stim_row_t r;
        r.kind         = ROW_CFG;
        r.stamp_valid  = 1'b0;
        r.stamp        = '0;
        r.count_enable = 1'b0;
        r.interval     = interval;
        r.typed        = 1'b0;
        r.want         = '0;
        stim_table.insert(stim_table.size(), r);
    endtask

    // offer one frame request, keeping valid high across back-to-back requests
    task automatic send_frame(input bit stamp_valid, input logic [tfd_pkg::STAMP_W-1:0] stamp,
                              input bit count_enable, input bit typed,
                              input frame_outcome_t want);
        frame_outcome_t predicted;
        frame_outcome_t owed;
        if (bursty && burst_left == 0)
        begin
            // gap between bursts
            frame_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
            burst_left = $urandom_range(1, 20);
        end
        frame_ch.valid        <= 1'b1;
        frame_ch.stamp_valid  <= stamp_valid;
        frame_ch.stamp        <= stamp;
        frame_ch.count_enable <= count_enable;
        @(posedge clk);
        while (!frame_ch.ready)
            @(posedge clk);
        // request accepted at this edge
        predicted = decimate_frame(stamp_valid, stamp, count_enable);
        owed      = typed ? want : predicted;
        pending_outcomes.insert(pending_outcomes.size(), owed);
        frames_sent++;
        if (burst_left > 0)
            burst_left--;
    endtask

    // stop offering frames until every owed outcome has come back
    task automatic wait_drain();
        frame_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending_outcomes.size() != 0)
            @(posedge clk);
    endtask

    // interval writes happen only with the block idle
    task automatic write_interval(input logic [tfd_pkg::IVL_W-1:0] interval);
        wait_drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= interval;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        cfg_ch.valid <= 1'b0;
        cur_interval = interval;
        interval_writes++;
    endtask

    // receiver: stall pattern of its own, plus one long hold-off on demand
    initial
    begin
        result_ch.ready = 1'b0;
        rx_pattern      = 16'hB5A7;
        hold_left       = 0;
        forever
        begin
            @(posedge clk);
            if (!rst_n)
                result_ch.ready <= 1'b0;
            else if (hold_left != 0)
            begin
                result_ch.ready <= 1'b0;
                hold_left--;
            end
            else if (hold_req)
            begin
                // block fills and back-pressures the frame side
                hold_req        = 1'b0;
                hold_left       = HOLD_CYCLES - 1;
                result_ch.ready <= 1'b0;
            end
            else if (!rx_stall_on)
                result_ch.ready <= 1'b1;
            else
            begin
                result_ch.ready <= rx_pattern[0];
                if ($urandom_range(0, 63) == 0)
                    rx_pattern = 16'($urandom) | 16'h0001;
                else
                    rx_pattern = {rx_pattern[0], rx_pattern[15:1]};
            end
        end
    end

    // compare each accepted result request with the oldest owed outcome
    always @(posedge clk)
    begin
        frame_outcome_t want;
        frame_outcome_t got;
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            got = '{result_ch.admit, result_ch.verdict, result_ch.admitted_total,
                    result_ch.dropped_total};
            if (pending_outcomes.size() == 0)
            begin
                mismatches++;
                if (mismatches <= SHOWN_MISMATCHES)
                    $display({"ERROR: result with none owed: admit %0b verdict %0d ",
                              "totals %0d/%0d"},
                             got.admit, got.verdict, got.admitted_total, got.dropped_total);
            end
            else
            begin
                want = pending_outcomes.pop_front();
                results_checked++;
                if (got.admit !== want.admit || got.verdict !== want.verdict ||
                    got.admitted_total !== want.admitted_total ||
                    got.dropped_total !== want.dropped_total)
                begin
                    mismatches++;
                    if (mismatches <= SHOWN_MISMATCHES)
                        $display({"ERROR: result %0d: expected admit %0b verdict %0d ",
                                  "totals %0d/%0d, got admit %0b verdict %0d totals %0d/%0d"},
                                 results_checked, want.admit, want.verdict,
                                 want.admitted_total, want.dropped_total, got.admit,
                                 got.verdict, got.admitted_total, got.dropped_total);
                end
            end
        end
    end

    // watchdog on cycles where no request moves on any channel
    always @(posedge clk)
    begin
        if (!rst_n)
            quiet_cycles <= 0;
        else if ((frame_ch.valid && frame_ch.ready) || (result_ch.valid && result_ch.ready) ||
                 (cfg_ch.valid && cfg_ch.ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("ERROR: no request accepted for %0d cycles, %0d outcomes owed",
                     quiet_cycles, pending_outcomes.size());
            $display("Verification failed");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // stimulus
    initial
    begin
        stim_row_t                   row;
        bit                          sv;
        bit                          ce;
        logic [tfd_pkg::STAMP_W-1:0] st;
        logic [tfd_pkg::STAMP_W-1:0] cursor;
        logic [tfd_pkg::TIME_W-1:0]  step;
        logic [tfd_pkg::IVL_W-1:0]   ivl_pick;
        int                          sel;

        rst_n                 = 1'b0;
        frame_ch.valid        = 1'b0;
        frame_ch.stamp_valid  = 1'b0;
        frame_ch.stamp        = '0;
        frame_ch.count_enable = 1'b0;
        cfg_ch.valid          = 1'b0;
        cfg_ch.data           = '0;

        // reset state of the predictor
        cur_interval = tfd_pkg::INTERVAL_RESET;
        due_ns       = '0;
        due_valid    = 1'b0;
        last_stamp   = '0;
        last_valid   = 1'b0;
        admitted     = '0;
        dropped      = '0;

        frames_sent     = 0;
        interval_writes = 0;
        results_checked = 0;
        mismatches      = 0;
        verdict_seen    = '{0, 0, 0, 0};
        burst_left      = 0;
        bursty          = 1'b1;
        rx_stall_on     = 1'b1;
        hold_req        = 1'b0;
        cursor          = '0;

        // directed table, reset interval of 125 ms first
        // untimed frame right after reset
        add_frame(1'b0, '0, 1'b1, 1'b1, 1'b1, tfd_pkg::VERDICT_UNTIMED, 32'd1, 32'd0);
        // first timed frame resyncs, due becomes 125000000
        add_frame(1'b1, '0, 1'b1, 1'b1, 1'b1, tfd_pkg::VERDICT_RESYNC, 32'd2, 32'd0);
        // one ns early
        add_frame(1'b1, 63'd124999999, 1'b1, 1'b1, 1'b0, tfd_pkg::VERDICT_DROP, 32'd2, 32'd1);
        // exactly on the due time
        add_frame(1'b1, 63'd125000000, 1'b1, 1'b1, 1'b1, tfd_pkg::VERDICT_SCHED, 32'd3, 32'd1);
        // same stamp again is not backwards, just early
        add_frame(1'b1, 63'd125000000, 1'b1, 1'b1, 1'b0, tfd_pkg::VERDICT_DROP, 32'd3, 32'd2);
        // skips several intervals, counting window closed
        add_frame(1'b1, 63'd1000000000, 1'b0, 1'b1, 1'b1, tfd_pkg::VERDICT_SCHED, 32'd3, 32'd2);
        // untimed with the largest stamp leaves the schedule alone
        add_frame(1'b0, STAMP_MAX, 1'b0, 1'b1, 1'b1, tfd_pkg::VERDICT_UNTIMED, 32'd3, 32'd2);
        // backwards stamp resyncs
        add_frame(1'b1, 63'd5, 1'b1, 1'b1, 1'b1, tfd_pkg::VERDICT_RESYNC, 32'd4, 32'd2);
        // largest stamp, huge number of intervals skipped
        add_frame(1'b1, STAMP_MAX, 1'b1, 1'b0, '0, '0, '0, '0);
        add_frame(1'b1, STAMP_MAX, 1'b1, 1'b0, '0, '0, '0, '0);
        add_frame(1'b1, 63'h2AAA_AAAA_AAAA_AAAA, 1'b1, 1'b0, '0, '0, '0, '0);
        add_frame(1'b1, 63'h5555_5555_5555_5555, 1'b0, 1'b0, '0, '0, '0, '0);
        // zero interval acts as one ns
        add_cfg('0);
        add_frame(1'b1, 63'd100, 1'b1, 1'b0, '0, '0, '0, '0);
        add_frame(1'b1, 63'd100, 1'b1, 1'b0, '0, '0, '0, '0);
        add_frame(1'b1, 63'd101, 1'b1, 1'b0, '0, '0, '0, '0);
        add_frame(1'b1, 63'd1000, 1'b1, 1'b0, '0, '0, '0, '0);
        // new interval only used at the next due-time update
        add_cfg(30'd1000000000);
        add_frame(1'b1, 63'd1001, 1'b1, 1'b0, '0, '0, '0, '0);
        add_frame(1'b1, 63'd2000, 1'b1, 1'b0, '0, '0, '0, '0);
        add_frame(1'b1, 63'd1000002000, 1'b0, 1'b0, '0, '0, '0, '0);
        // widest interval the field holds
        add_cfg(IVL_MAX);
        add_frame(1'b1, STAMP_MAX - 63'd7, 1'b1, 1'b0, '0, '0, '0, '0);
        add_frame(1'b1, STAMP_MAX, 1'b1, 1'b0, '0, '0, '0, '0);
        add_frame(1'b1, 63'd0, 1'b1, 1'b0, '0, '0, '0, '0);

        // hold reset, release at a rising edge
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (stim_table[i])
        begin
            row = stim_table[i];
            if (row.kind == ROW_CFG)
                write_interval(row.interval);
            else
                send_frame(row.stamp_valid, row.stamp, row.count_enable, row.typed, row.want);
        end
        directed_frames = frames_sent;

        // random phases, one interval setting each
        for (int ph = 0; ph < PHASES; ph++)
        begin
            case (ph)
                0:       ivl_pick = 30'd1;
                1:       ivl_pick = tfd_pkg::IVL_W'($urandom_range(2, 64));
                2:       ivl_pick = tfd_pkg::IVL_W'($urandom_range(1000, 100000));
                3:       ivl_pick = tfd_pkg::INTERVAL_RESET;
                4:       ivl_pick = 30'd1000000000;
                5:       ivl_pick = tfd_pkg::IVL_W'($urandom);
                6:       ivl_pick = '0;
                default: ivl_pick = IVL_MAX;
            endcase
            write_interval(ivl_pick);
            bursty      = (ph % 3) != 2;
            rx_stall_on = (ph % 4) != 3;
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                // long receiver hold-off while frames keep coming
                if (ph == 2 && n == 40)
                    hold_req = 1'b1;
                // sender pauses until the block has caught up
                if (ph == 5 && n == 60)
                    wait_drain();
                sel  = $urandom_range(0, 15);
                sv   = 1'b1;
                ce   = ($urandom_range(0, 3) != 0);
                step = (cur_interval == '0) ? tfd_pkg::TIME_W'(1)
                                            : tfd_pkg::TIME_W'(cur_interval);
                case (sel) inside
                    // mostly a steady stream around the interval
                    [0:7]:
                        st = tfd_pkg::STAMP_W'(tfd_pkg::TIME_W'(cursor)
                             + ((step * tfd_pkg::TIME_W'($urandom_range(0, 12))) >> 2)
                             + tfd_pkg::TIME_W'($urandom_range(0, 1)));
                    8:  st = tfd_pkg::STAMP_W'(tfd_pkg::TIME_W'(cursor)
                             + step * tfd_pkg::TIME_W'($urandom_range(2, 1000)));
                    9:  st = tfd_pkg::STAMP_W'(due_ns);
                    10: st = tfd_pkg::STAMP_W'(due_ns - tfd_pkg::TIME_W'(1));
                    11: st = cursor;
                    12: st = tfd_pkg::STAMP_W'(tfd_pkg::TIME_W'(cursor)
                             - tfd_pkg::TIME_W'($urandom_range(1, 64)) - (step >> 1));
                    13: st = tfd_pkg::STAMP_W'({$urandom, $urandom});
                    14: st = STAMP_MAX - tfd_pkg::STAMP_W'($urandom_range(0, 1000));
                    default:
                    begin
                        sv = 1'b0;
                        st = tfd_pkg::STAMP_W'({$urandom, $urandom});
                    end
                endcase
                if (sv)
                    cursor = st;
                send_frame(sv, st, ce, 1'b0, '0);
            end
        end

        // drain and let the pipeline run empty
        wait_drain();
        repeat (END_CYCLES) @(posedge clk);

        $display("run covered %0d frames (%0d directed) over %0d interval writes",
                 frames_sent, directed_frames, interval_writes);
        $display({"%0d results checked; verdicts: untimed %0d, resync %0d, early drop %0d, ",
                  "scheduled %0d; mismatches %0d"},
                 results_checked, verdict_seen[tfd_pkg::VERDICT_UNTIMED],
                 verdict_seen[tfd_pkg::VERDICT_RESYNC], verdict_seen[tfd_pkg::VERDICT_DROP],
                 verdict_seen[tfd_pkg::VERDICT_SCHED], mismatches);
        if (mismatches == 0 && pending_outcomes.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
